>>> hdl/alfl_pkg.sv
`default_nettype none

package alfl_pkg;

    // Default number of record slots in the table.
    localparam int MAX_RECORDS_DEF = 64;

    // Width of the fixed interface fields.
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 64;
    localparam int COUNT_W = 7;

    // Command codes. The last code is accepted and ignored.
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_LINK,
        S_WALK,
        S_UNLINK,
        S_FREE,
        S_RESP
    } t_state;

    // One command item.
    typedef struct packed {
        t_cmd                     cmd;
        logic signed [KEY_W-1:0]  key;
        logic        [PAY_W-1:0]  payload;
    } t_in;

    // One result item.
    typedef struct packed {
        t_status                  status;
        logic signed [KEY_W-1:0]  found_key;
        logic        [PAY_W-1:0]  found_payload;
        logic        [COUNT_W-1:0] record_count;
    } t_out;

endpackage

`default_nettype wire

>>> hdl/alfl_ram.sv
`default_nettype none

module alfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/array_linked_list_with_free_list.sv
// Sequence: an append passes S_APPEND, S_LINK and S_RESP before the result register is
// loaded; a search walks the list in S_WALK, and a remove walks it and then passes S_UNLINK
// and S_FREE. A walk visits 1 to MAX_RECORDS slots, one slot per read of the shared memories.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset: synchronous and active low; the lists are empty and all slots free at once,
// since untouched slots are tracked by a fill count instead of a clearing pass.
`default_nettype none

module array_linked_list_with_free_list #(
    parameter int MAX_RECORDS = alfl_pkg::MAX_RECORDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire alfl_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output alfl_pkg::t_out     o_out
);

    import alfl_pkg::*;

    // Slot index width and link width; the link value MAX_RECORDS is null.
    localparam int AW  = $clog2(MAX_RECORDS);
    localparam int PW  = $clog2(MAX_RECORDS + 1);
    localparam int RW  = KEY_W + PAY_W;
    localparam logic [PW-1:0] NIL = PW'(MAX_RECORDS);

    // Control state.
    t_state        r_state, n_state;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_steps, n_steps;
    logic          r_out_valid, n_out_valid;

    // Working and result data.
    t_cmd                    r_cmd, n_cmd;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0]        r_pay, n_pay;
    logic [AW-1:0]           r_cur, n_cur;
    logic [PW-1:0]           r_prev_lnk, n_prev_lnk;
    logic [PW-1:0]           r_next_lnk, n_next_lnk;
    t_status                 r_status, n_status;
    logic signed [KEY_W-1:0] r_fkey, n_fkey;
    logic [PAY_W-1:0]        r_fpay, n_fpay;
    t_out                    r_out, n_out;

    // Memory ports. All three memories share one read address.
    logic [AW-1:0] rd_addr;
    logic          rec_we, next_we, prev_we;
    logic [AW-1:0] rec_waddr, next_waddr, prev_waddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic [PW-1:0] next_wdata, next_rdata;
    logic [PW-1:0] prev_wdata, prev_rdata;
    logic [PW-1:0] steps_inc;

    alfl_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rec_rdata)
    );

    alfl_ram #(.WIDTH(PW), .DEPTH(MAX_RECORDS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (rd_addr),
        .o_rdata (next_rdata)
    );

    alfl_ram #(.WIDTH(PW), .DEPTH(MAX_RECORDS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (rd_addr),
        .o_rdata (prev_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign steps_inc   = r_steps + PW'(1);

    // Sequencer: next state, list pointers and memory controls.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_fill      = r_fill;
        n_count     = r_count;
        n_steps     = r_steps;
        n_out_valid = r_out_valid && i_out_stall;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pay       = r_pay;
        n_cur       = r_cur;
        n_prev_lnk  = r_prev_lnk;
        n_next_lnk  = r_next_lnk;
        n_status    = r_status;
        n_fkey      = r_fkey;
        n_fpay      = r_fpay;
        n_out       = r_out;

        rd_addr    = r_cur;
        rec_we     = 1'b0;
        rec_waddr  = r_cur;
        rec_wdata  = {r_key, r_pay};
        next_we    = 1'b0;
        next_waddr = r_cur;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = r_cur;
        prev_wdata = r_tail;

        unique case (r_state)
            S_IDLE: begin
                // An append reads the free slot's link, a walk reads the head slot.
                if (i_in.cmd == CMD_APPEND) begin
                    rd_addr = r_free[AW-1:0];
                end else begin
                    rd_addr = r_head[AW-1:0];
                end
                if (i_in_valid) begin
                    n_cmd    = i_in.cmd;
                    n_key    = i_in.key;
                    n_pay    = i_in.payload;
                    n_fkey   = '0;
                    n_fpay   = '0;
                    n_status = STAT_DONE;
                    n_steps  = '0;
                    unique case (i_in.cmd)
                        CMD_APPEND: begin
                            if (r_free < NIL) begin
                                n_state = S_APPEND;
                            end else begin
                                n_status = STAT_FULL;
                                n_state  = S_RESP;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH: begin
                            if (r_head < NIL) begin
                                n_cur   = r_head[AW-1:0];
                                n_state = S_WALK;
                            end else begin
                                n_status = STAT_EMPTY;
                                n_state  = S_RESP;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_APPEND: begin
                // Fill the slot and pop it off the free list. A slot at the fill
                // mark has never been used, so its link is simply the next slot.
                n_cur      = r_free[AW-1:0];
                rec_we     = 1'b1;
                rec_waddr  = r_free[AW-1:0];
                next_we    = 1'b1;
                next_waddr = r_free[AW-1:0];
                next_wdata = NIL;
                prev_we    = 1'b1;
                prev_waddr = r_free[AW-1:0];
                prev_wdata = r_tail;
                if (r_free >= r_fill) begin
                    n_free = r_free + PW'(1);
                    n_fill = r_fill + PW'(1);
                end else begin
                    n_free = next_rdata;
                end
                n_state = S_LINK;
            end

            S_LINK: begin
                // Hook the new slot behind the old tail.
                if (r_tail < NIL) begin
                    next_we    = 1'b1;
                    next_waddr = r_tail[AW-1:0];
                    next_wdata = PW'(r_cur);
                end else begin
                    n_head = PW'(r_cur);
                end
                n_tail   = PW'(r_cur);
                n_count  = r_count + PW'(1);
                n_status = STAT_DONE;
                n_state  = S_RESP;
            end

            S_WALK: begin
                // Compare one slot per cycle and steer the read to its successor.
                if (rec_rdata[RW-1:PAY_W] == r_key) begin
                    n_fkey     = rec_rdata[RW-1:PAY_W];
                    n_fpay     = rec_rdata[PAY_W-1:0];
                    n_prev_lnk = prev_rdata;
                    n_next_lnk = next_rdata;
                    n_status   = STAT_DONE;
                    if (r_cmd == CMD_REMOVE) begin
                        n_state = S_UNLINK;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_steps = steps_inc;
                    if ((steps_inc == NIL) || !(next_rdata < NIL)) begin
                        n_status = STAT_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        rd_addr = next_rdata[AW-1:0];
                        n_cur   = next_rdata[AW-1:0];
                    end
                end
            end

            S_UNLINK: begin
                // Bridge the neighbors, or move the head or tail for an end slot.
                if (r_prev_lnk < NIL) begin
                    next_we    = 1'b1;
                    next_waddr = r_prev_lnk[AW-1:0];
                    next_wdata = r_next_lnk;
                end else begin
                    n_head = r_next_lnk;
                end
                if (r_next_lnk < NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = r_next_lnk[AW-1:0];
                    prev_wdata = r_prev_lnk;
                end else begin
                    n_tail = r_prev_lnk;
                end
                if (r_count != '0) begin
                    n_count = r_count - PW'(1);
                end
                n_state = S_FREE;
            end

            S_FREE: begin
                // Push the removed slot onto the free list.
                next_we    = 1'b1;
                next_waddr = r_cur;
                next_wdata = r_free;
                n_free     = PW'(r_cur);
                n_state    = S_RESP;
            end

            S_RESP: begin
                // Load the result once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status        = r_status;
                    n_out.found_key     = r_fkey;
                    n_out.found_payload = r_fpay;
                    n_out.record_count  = COUNT_W'(r_count);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_free      <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result data.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_cur      <= n_cur;
        r_prev_lnk <= n_prev_lnk;
        r_next_lnk <= n_next_lnk;
        r_status   <= n_status;
        r_fkey     <= n_fkey;
        r_fpay     <= n_fpay;
        r_out      <= n_out;
    end

    // The record count never passes the table size, and neither does the fill mark.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= NIL) && (r_fill <= NIL))
        else $error("record count or fill mark beyond table size");

    // An empty list has no head and no tail, and a non-empty one has both.
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (((r_head == NIL) == (r_count == '0)) &&
                                 ((r_tail == NIL) == (r_head == NIL))))
        else $error("head, tail and record count disagree");

    // A walk never runs past the table size.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps < NIL))
        else $error("list walk ran past the table size");

    // A freed slot becomes the head of the free list.
    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |=> (r_free == PW'($past(r_cur))))
        else $error("removed slot not pushed onto the free list");

    // A pending result only leaves the output register through a transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

>>> sim/array_linked_list_with_free_list_test.sv
`timescale 1ns / 1ps

module array_linked_list_with_free_list_test;
    import alfl_pkg::*;

    localparam int SLOTS         = MAX_RECORDS_DEF;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int DRAIN_CYCLES  = 80;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PRESSURE_AT   = 500;
    localparam int PRESSURE_LEN  = 400;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // Command mixes for the random episodes.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_CHURN
    } t_mix;

    // One linked record, in list order.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] payload;
    } t_record;

    logic   i_clk    = 1'b0;
    logic   i_rst_n  = 1'b0;
    logic   in_valid = 1'b0;
    t_in    in_item  = '0;
    logic   out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_out   out_item;

    t_in     pending_commands[$];
    t_out    awaited_results[$];
    t_record linked_records[$];

    int   failures      = 0;
    int   results_taken = 0;
    int   send_gap      = 0;
    int   hold_left     = 0;
    int   idle_cycles   = 0;
    bit   send_quiet    = 1'b0;
    bit   recv_quiet    = 1'b0;
    logic hold_out      = 1'b0;

    array_linked_list_with_free_list #(
        .MAX_RECORDS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the list of records and return the result it causes.
    // Slot numbering is invisible at the ports, so the list is kept in link order.
    function automatic t_out apply_command(t_in c);
        t_out r;
        int   hit;
        r = '0;
        r.status = STAT_DONE;
        hit = -1;
        case (c.cmd)
            CMD_APPEND: begin
                if (linked_records.size() >= SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    linked_records.push_back('{key: c.key, payload: c.payload});
                end
            end
            CMD_REMOVE, CMD_SEARCH: begin
                if (linked_records.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // The walk from the head stops at the first matching key.
                    foreach (linked_records[i]) begin
                        if (hit < 0 && linked_records[i].key == c.key) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.found_key     = linked_records[hit].key;
                        r.found_payload = linked_records[hit].payload;
                        if (c.cmd == CMD_REMOVE) linked_records.delete(hit);
                    end
                end
            end
            default: ;
        endcase
        r.record_count = COUNT_W'(linked_records.size());
        return r;
    endfunction

    task automatic note_failure(string what);
        $display("[%0t] mismatch: %s", $time, what);
        failures++;
    endtask

    // Compare one result transfer with the oldest expected result.
    task automatic check_result(t_out got);
        t_out want;
        if (awaited_results.size() == 0) begin
            note_failure($sformatf("result with nothing expected, status %0d key %0d",
                                   got.status, got.found_key));
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status)
            note_failure($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.found_key !== want.found_key)
            note_failure($sformatf("found_key got %0d want %0d",
                                   got.found_key, want.found_key));
        if (got.found_payload !== want.found_payload)
            note_failure($sformatf("found_payload got %h want %h",
                                   got.found_payload, want.found_payload));
        if (got.record_count !== want.record_count)
            note_failure($sformatf("record_count got %0d want %0d",
                                   got.record_count, want.record_count));
    endtask

    task automatic queue_command(t_cmd cmd, logic signed [KEY_W-1:0] key,
                                 logic [PAY_W-1:0] payload);
        t_in c;
        c.cmd     = cmd;
        c.key     = key;
        c.payload = payload;
        pending_commands.push_back(c);
    endtask

    function automatic t_cmd pick_command(t_mix mix);
        int roll;
        int append_pct;
        int remove_pct;
        int search_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                append_pct = 80; remove_pct = 8;  search_pct = 8;
            end
            MIX_SHRINK: begin
                append_pct = 20; remove_pct = 60; search_pct = 15;
            end
            default: begin
                append_pct = 40; remove_pct = 30; search_pct = 25;
            end
        endcase
        if (roll < append_pct) return CMD_APPEND;
        if (roll < append_pct + remove_pct) return CMD_REMOVE;
        if (roll < append_pct + remove_pct + search_pct) return CMD_SEARCH;
        return CMD_NOP;
    endfunction

    // Mostly a small pool of keys, negatives included, so that lookups hit and
    // duplicates occur; the rest spans the whole key range.
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 47)) - 16;
        return $urandom();
    endfunction

    // Driver: offers queued commands with random gaps and predicts each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            send_gap = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                awaited_results.push_back(apply_command(in_item));
            end
            if (!in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_commands.size() > 0) begin
                    in_item  <= pending_commands.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
                    send_gap = send_quiet ? 0 : $urandom_range(0, 13);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and draws the stall before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_result(out_item);
                results_taken++;
                if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
                hold_left = recv_quiet ? 0 : $urandom_range(0, 13);
            end else if (o_out_valid && hold_left > 0) begin
                hold_left--;
            end
            out_stall <= hold_out || hold_left > 0;
        end
    end

    // Hold the receiver off once for a long stretch so the block backs up.
    initial begin
        while (results_taken < PRESSURE_AT) @(negedge i_clk);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (PRESSURE_LEN) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_mix mix;
        t_cmd cmd;
        int   run;
        int   random_count;
        bit   first_run;

        // Directed commands: empty list, ignored code, key and payload extremes,
        // duplicate keys, and removal at the head, middle and tail.
        queue_command(CMD_SEARCH, 0, '0);
        queue_command(CMD_REMOVE, -1, '1);
        queue_command(CMD_NOP, $urandom(), {$urandom(), $urandom()});
        queue_command(CMD_APPEND, KEY_MIN, '0);
        queue_command(CMD_APPEND, KEY_MAX, '1);
        queue_command(CMD_APPEND, 0, 64'h5555_5555_5555_5555);
        queue_command(CMD_APPEND, -1, 64'haaaa_aaaa_aaaa_aaaa);
        queue_command(CMD_APPEND, 5, 64'h0123_4567_89ab_cdef);
        queue_command(CMD_APPEND, 5, 64'hfedc_ba98_7654_3210);
        queue_command(CMD_SEARCH, 5, '0);
        queue_command(CMD_SEARCH, 12345, '0);
        queue_command(CMD_REMOVE, KEY_MIN, '0);
        queue_command(CMD_REMOVE, 0, '0);
        queue_command(CMD_REMOVE, 5, '0);
        queue_command(CMD_REMOVE, 5, '0);
        queue_command(CMD_REMOVE, 7, '0);
        queue_command(CMD_NOP, KEY_MAX, '1);
        queue_command(CMD_REMOVE, KEY_MAX, '0);
        queue_command(CMD_REMOVE, -1, '0);
        queue_command(CMD_SEARCH, -1, '0);
        queue_command(CMD_APPEND, 3, {$urandom(), $urandom()});

        // Random episodes; the first one grows the list until the table is full.
        random_count = 0;
        first_run = 1'b1;
        mix = MIX_GROW;
        while (random_count < RANDOM_ITEMS) begin
            run = first_run ? 140 : $urandom_range(40, 160);
            repeat (run) begin
                cmd = pick_command(mix);
                queue_command(cmd, pick_key(), {$urandom(), $urandom()});
                if (cmd != CMD_NOP) random_count++;
            end
            first_run = 1'b0;
            mix = t_mix'($urandom_range(0, 2));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every result to come back.
        while (pending_commands.size() > 0 || in_valid || awaited_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
